// ----- rtl/core/search_query_syntax_checker_macros.svh -----
// Assertion macros shared by the checker's RTL files.
// SQSC_ASSERT checks that a property holds at every clock edge out of reset.
// SQSC_NEVER checks that a condition is never true out of reset.
`ifndef SEARCH_QUERY_SYNTAX_CHECKER_MACROS_SVH
`define SEARCH_QUERY_SYNTAX_CHECKER_MACROS_SVH

`ifndef SYNTH
`define SQSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SQSC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define SQSC_ASSERT(lbl, prop, msg)
`define SQSC_NEVER(lbl, cond, msg)
`endif

`endif

// ----- rtl/core/sqsc_pkg.sv -----
package sqsc_pkg;

	localparam int MAX_LEN    = 4096;
	localparam int POS_W      = $clog2(MAX_LEN + 1);
	localparam int COUNT_MAX  = 4096;
	localparam int CNT_W      = 13;
	localparam int CH_W       = 8;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [2:0]       cls_t;

	// Character classes handed from the front to the back.
	localparam cls_t CLS_QUOTE = 3'd0;
	localparam cls_t CLS_OPEN  = 3'd1;
	localparam cls_t CLS_CLOSE = 3'd2;
	localparam cls_t CLS_OP    = 3'd3;
	localparam cls_t CLS_SPACE = 3'd4;
	localparam cls_t CLS_OTHER = 3'd5;
	localparam cls_t CLS_TERM  = 3'd6;

	localparam logic [CH_W-1:0] CHR_QUOTE = 8'h22;
	localparam logic [CH_W-1:0] CHR_OPEN  = 8'h28;
	localparam logic [CH_W-1:0] CHR_CLOSE = 8'h29;
	localparam logic [CH_W-1:0] CHR_PLUS  = 8'h2B;
	localparam logic [CH_W-1:0] CHR_MINUS = 8'h2D;
	localparam logic [CH_W-1:0] CHR_BAR   = 8'h7C;
	localparam logic [CH_W-1:0] CHR_SPACE = 8'h20;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ----- rtl/core/sqsc_if.sv -----
interface sqsc_in_if import sqsc_pkg::*;;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] ch;
	logic            terminator;

	modport source (output valid, output ch, output terminator, input ready);
	modport sink (input valid, input ch, input terminator, output ready);
endinterface

interface sqsc_out_if import sqsc_pkg::*;;
	logic       valid;
	logic       ready;
	logic       well_formed;
	cnt_t       word_count;

	modport source (output valid, output well_formed, output word_count, input ready);
	modport sink (input valid, input well_formed, input word_count, output ready);
endinterface

// ----- rtl/core/sqsc_front.sv -----
module sqsc_front import sqsc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	sqsc_in_if.sink qry,
	input  q_stat_t q_stat,
	output logic    q_push,
	output cls_t    q_cls
);

	logic valid_s1;
	cls_t cls_s1;
	cls_t cls;

	always_comb begin
		if (qry.terminator) begin
			cls = CLS_TERM;
		end else begin
			unique case (qry.ch) inside
				CHR_QUOTE:                    cls = CLS_QUOTE;
				CHR_OPEN:                     cls = CLS_OPEN;
				CHR_CLOSE:                    cls = CLS_CLOSE;
				CHR_PLUS, CHR_MINUS, CHR_BAR: cls = CLS_OP;
				CHR_SPACE:                    cls = CLS_SPACE;
				default:                      cls = CLS_OTHER;
			endcase
		end
	end

	assign qry.ready = !valid_s1 || !q_stat.full;
	assign q_push    = valid_s1 && !q_stat.full;
	assign q_cls     = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (qry.ready) begin
			valid_s1 <= qry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (qry.valid && qry.ready) begin
			cls_s1 <= cls;
		end
	end

endmodule

// ----- rtl/core/sqsc_fifo.sv -----
`include "search_query_syntax_checker_macros.svh"

module sqsc_fifo import sqsc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cls_t    din,
	input  logic    pop,
	output cls_t    dout,
	output q_stat_t stat
);

	cls_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] cnt_q;

	assign dout       = mem_q[rd_ptr_q];
	assign stat.full  = cnt_q == FIFO_CW'(FIFO_DEPTH);
	assign stat.empty = cnt_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	`SQSC_ASSERT(a_fifo_cnt_range, cnt_q <= FIFO_CW'(FIFO_DEPTH), "queue count out of range")
	`SQSC_NEVER(a_fifo_pop_empty, pop && cnt_q == '0, "pop from empty queue")
	`SQSC_NEVER(a_fifo_push_full, push && !pop && stat.full, "push into full queue")

endmodule

// ----- rtl/core/sqsc_back.sv -----
`include "search_query_syntax_checker_macros.svh"

module sqsc_back import sqsc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_stat_t   q_stat,
	input  cls_t      q_cls,
	output logic      q_pop,
	sqsc_out_if.source res
);

	// Last positions are kept as position plus one, so zero means none.
	pos_t pos_q, depth_q;
	pos_t open_q, close_q, op_q, quote_q, other_q;
	logic inq_q, inw_q, err_q;
	cnt_t op_cnt_q;
	logic out_valid_q, wf_q;
	cnt_t wc_q;

	pos_t n_pos, n_depth, n_open, n_close, n_op, n_quote, n_other;
	logic n_inq, n_inw, n_err;
	cnt_t n_op_cnt;
	cls_t eff_cls;
	pos_t here;
	logic fail;
	logic is_term;
	logic wf;

	assign is_term = q_cls == CLS_TERM;
	assign q_pop   = !q_stat.empty && (!is_term || !out_valid_q || res.ready);

	// Operator characters inside quotes count as ordinary word characters.
	assign eff_cls = (q_cls == CLS_OP && inq_q) ? CLS_OTHER : q_cls;
	assign here    = pos_q + 1'b1;

	assign wf = !err_q && !(op_q > other_q) && !(other_q == '0 && quote_q == '0) &&
		depth_q == '0 && !inq_q;

	always_comb begin
		n_pos    = pos_q;
		n_depth  = depth_q;
		n_open   = open_q;
		n_close  = close_q;
		n_op     = op_q;
		n_quote  = quote_q;
		n_other  = other_q;
		n_inq    = inq_q;
		n_inw    = inw_q;
		n_err    = err_q;
		n_op_cnt = op_cnt_q;

		unique case (eff_cls)
			CLS_QUOTE: fail = !inq_q && (other_q > op_q);
			CLS_OPEN:  fail = other_q > op_q;
			CLS_CLOSE: fail = depth_q == '0;
			CLS_OP:    fail = other_q == '0 || op_q > other_q || open_q > other_q;
			CLS_OTHER: fail = (close_q > op_q) || (!inq_q && quote_q > op_q) ||
				(!inq_q && !inw_q && other_q > op_q);
			default:   fail = 1'b0;
		endcase
		if (pos_q == POS_W'(MAX_LEN)) begin
			fail = 1'b1;
		end

		if (!err_q) begin
			if (fail) begin
				n_err = 1'b1;
			end else begin
				n_pos = here;
				unique case (eff_cls)
					CLS_QUOTE: begin
						n_inq   = !inq_q;
						n_quote = here;
					end
					CLS_OPEN: begin
						n_depth = depth_q + 1'b1;
						n_open  = here;
					end
					CLS_CLOSE: begin
						n_depth = depth_q - 1'b1;
						n_close = here;
					end
					CLS_OP: begin
						n_op = here;
						if (op_cnt_q < CNT_W'(COUNT_MAX)) begin
							n_op_cnt = op_cnt_q + 1'b1;
						end
					end
					CLS_OTHER: begin
						n_inw   = 1'b1;
						n_other = here;
					end
					CLS_SPACE: begin
						if (!inq_q) begin
							n_inw = 1'b0;
						end
					end
					default: begin
						n_pos = pos_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			depth_q     <= '0;
			open_q      <= '0;
			close_q     <= '0;
			op_q        <= '0;
			quote_q     <= '0;
			other_q     <= '0;
			inq_q       <= 1'b0;
			inw_q       <= 1'b0;
			err_q       <= 1'b0;
			op_cnt_q    <= CNT_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop && is_term) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop && is_term) begin
				pos_q       <= '0;
				depth_q     <= '0;
				open_q      <= '0;
				close_q     <= '0;
				op_q        <= '0;
				quote_q     <= '0;
				other_q     <= '0;
				inq_q       <= 1'b0;
				inw_q       <= 1'b0;
				err_q       <= 1'b0;
				op_cnt_q    <= CNT_W'(1);
			end else if (q_pop) begin
				pos_q    <= n_pos;
				depth_q  <= n_depth;
				open_q   <= n_open;
				close_q  <= n_close;
				op_q     <= n_op;
				quote_q  <= n_quote;
				other_q  <= n_other;
				inq_q    <= n_inq;
				inw_q    <= n_inw;
				err_q    <= n_err;
				op_cnt_q <= n_op_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && is_term) begin
			wf_q <= wf;
			wc_q <= op_cnt_q;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.well_formed = wf_q;
	assign res.word_count  = wc_q;

	`SQSC_ASSERT(a_depth_le_pos, depth_q <= pos_q, "bracket depth exceeds position")
	`SQSC_ASSERT(a_err_freezes, err_q && !(q_pop && is_term) |=> $stable(pos_q), "state moved after error")
	`SQSC_ASSERT(a_term_result, q_pop && is_term |=> res.valid, "terminator gave no result")

endmodule

// ----- rtl/core/search_query_syntax_checker.sv -----
// A terminator transaction passes through the front register, the queue and the result
// register before its result shows; a stall on either side can hold it in between.
// Throughput: one character or terminator per cycle while nothing stalls; the back updates all state.
// A four-entry queue between front and back absorbs short stalls on either side.
// Reset: arst_n clears all control and query state at once; no clearing pass is needed.
module search_query_syntax_checker import sqsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	sqsc_in_if.sink    qry,
	sqsc_out_if.source res
);

	q_stat_t q_stat;
	logic    q_push;
	logic    q_pop;
	cls_t    push_cls;
	cls_t    pop_cls;

	sqsc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.qry    (qry),
		.q_stat (q_stat),
		.q_push (q_push),
		.q_cls  (push_cls)
	);

	sqsc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (push_cls),
		.pop    (q_pop),
		.dout   (pop_cls),
		.stat   (q_stat)
	);

	sqsc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.q_cls  (pop_cls),
		.q_pop  (q_pop),
		.res    (res)
	);

endmodule
